// File: rtl/core/dalitz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dalitz boundary check package
// Shared widths, register indexes and payload types.
// ----------------------------------------------------------------------------
package dalitz_pkg;

    localparam int MASS_W        = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_BITS_DEF = 24;

    // Width of a numerator with its carry bit kept.
    localparam int NUM_W = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOTHER_MASS_SQ = 3'd0,
        REG_A_MASS_SQ      = 3'd1,
        REG_B_MASS_SQ      = 3'd2,
        REG_C_MASS_SQ      = 3'd3,
        REG_AC_RANGE_MIN   = 3'd4,
        REG_AC_RANGE_MAX   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [MASS_W-1:0] ab_sq;
        logic [MASS_W-1:0] ac_sq;
    } point_t;

    typedef struct packed {
        logic              in_plot;
        logic              ac_out_of_range;
        logic [MASS_W-1:0] ab_lower;
        logic [MASS_W-1:0] ab_upper;
    } bounds_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [MASS_W-1:0]    data;
    } cfg_wr_t;

    // The block's configuration, as one bundle handed to the datapath.
    typedef struct packed {
        logic [MASS_W-1:0] mother_mass_sq;
        logic [MASS_W-1:0] a_mass_sq;
        logic [MASS_W-1:0] b_mass_sq;
        logic [MASS_W-1:0] c_mass_sq;
        logic [MASS_W-1:0] ac_range_min;
        logic [MASS_W-1:0] ac_range_max;
    } cfg_t;

endpackage

// File: rtl/core/dalitz_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dalitz stream interfaces
// Valid/ready channels for points, results and configuration writes.
// ----------------------------------------------------------------------------
interface dalitz_point_if;
    logic               valid;
    logic               ready;
    dalitz_pkg::point_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dalitz_bounds_if;
    logic                valid;
    logic                ready;
    dalitz_pkg::bounds_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dalitz_cfg_if;
    logic                valid;
    logic                ready;
    dalitz_pkg::cfg_wr_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/dalitz_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dalitz pipelined square root
// Floor square root of a 64-bit value, two result bits per stage.
// ----------------------------------------------------------------------------
module dalitz_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [31:0]       out_root,
    output logic [SIDE_W-1:0] out_side
);
    // Each stage resolves two root bits (two digits of the classic method).
    localparam int STAGES = 16;

    logic [63:0]       x_reg    [STAGES+1];
    logic [63:0]       r_reg    [STAGES+1];
    logic [SIDE_W-1:0] side_reg [STAGES+1];
    logic              v_reg    [STAGES+1];

    always_comb
    begin
        x_reg[0]    = in_rad;
        r_reg[0]    = '0;
        side_reg[0] = in_side;
        v_reg[0]    = in_valid;
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [63:0] x_next;
        logic [63:0] r_next;
        logic [63:0] x_cur;
        logic [63:0] r_cur;
        logic [63:0] bit_v;
        always_comb
        begin
            x_cur = x_reg[s];
            r_cur = r_reg[s];
            for (int k = 0; k < 2; k++)
            begin
                bit_v = 64'd1 << (62 - 2 * (2 * s + k));
                if (x_cur >= r_cur + bit_v)
                begin
                    x_cur = x_cur - (r_cur + bit_v);
                    r_cur = (r_cur >> 1) + bit_v;
                end
                else
                begin
                    r_cur = r_cur >> 1;
                end
            end
            x_next = x_cur;
            r_next = r_cur;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s+1]    <= x_next;
                r_reg[s+1]    <= r_next;
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_root  = r_reg[STAGES][31:0];
    assign out_side  = side_reg[STAGES];
endmodule

// File: rtl/core/dalitz_boundary_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dalitz boundary check
// Decides whether an (AB, AC) squared-mass point lies inside the Dalitz plot.
// ----------------------------------------------------------------------------
// The block accepts one point in every clock cycle while its output is not
// stalled and returns one result item for each point, in order, through the
// numerator stage, two multiplier stages, 66 divider stages (one quotient
// digit per stage for each of the three energy terms, side by side), two
// stages for the clamp and momentum product, 16 square-root stages and two
// stages for the bounds and the compare. The whole pipe advances together;
// when the output is stalled every stage holds, so nothing is lost, and the
// input is held off for exactly the cycles in which the output holds an
// untaken item. An output register sits at the end, and the input stays
// ready while the final stage is empty or being drained. Configuration is
// written through its own channel, which is always ready; the user is to write
// it only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dalitz_boundary_check #(
    parameter int FRAC_BITS = dalitz_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    dalitz_cfg_if.sink      cfg,
    dalitz_point_if.sink    point,
    dalitz_bounds_if.source bounds
);
    localparam int W     = dalitz_pkg::MASS_W;
    localparam int DIV_N = 66;   // quotient digits: 66-bit product over 34-bit divisor
    localparam logic [W-1:0] SAT32 = '1;

    // The formulas are homogeneous in squared masses, so the binary point
    // only matters for interpretation. The parameter stays as documentation
    // of the format and guards its range.
    localparam int FB_CHECK = (FRAC_BITS >= 16 && FRAC_BITS <= 40) ? 1 : 0;

    dalitz_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid && FB_CHECK == 1)
        begin
            unique case (cfg.data.index)
                dalitz_pkg::REG_MOTHER_MASS_SQ: cfg_reg.mother_mass_sq <= cfg.data.data;
                dalitz_pkg::REG_A_MASS_SQ:      cfg_reg.a_mass_sq      <= cfg.data.data;
                dalitz_pkg::REG_B_MASS_SQ:      cfg_reg.b_mass_sq      <= cfg.data.data;
                dalitz_pkg::REG_C_MASS_SQ:      cfg_reg.c_mass_sq      <= cfg.data.data;
                dalitz_pkg::REG_AC_RANGE_MIN:   cfg_reg.ac_range_min   <= cfg.data.data;
                dalitz_pkg::REG_AC_RANGE_MAX:   cfg_reg.ac_range_max   <= cfg.data.data;
                default: ;
            endcase
        end
    end

    // Global pipeline enable: advance unless the output holds an untaken item.
    logic out_valid_reg;
    logic en;
    assign en          = !out_valid_reg || bounds.ready;
    assign point.ready = en;

    // ---------------- Stage 1: range check and numerators ----------------
    logic          s1_valid_reg;
    logic          s1_oor_reg;
    logic [W-1:0]  s1_ab_reg;
    logic [W-1:0]  s1_na_reg;
    logic [W-1:0]  s1_nb_reg;
    logic [W+1:0]  s1_den_reg;

    logic [W:0] t_a;
    logic [W:0] t_b;
    logic [W:0] na_next;
    logic [W:0] nb_next;
    always_comb
    begin
        t_a = {1'b0, point.data.ac_sq} + {1'b0, cfg_reg.a_mass_sq};
        t_b = {1'b0, point.data.ac_sq} + {1'b0, cfg_reg.b_mass_sq};
        na_next = (t_a >= {1'b0, cfg_reg.c_mass_sq}) ? t_a - {1'b0, cfg_reg.c_mass_sq}
                                                       : {1'b0, cfg_reg.c_mass_sq} - t_a;
        nb_next = ({1'b0, cfg_reg.mother_mass_sq} >= t_b)
                ? {1'b0, cfg_reg.mother_mass_sq} - t_b
                : t_b - {1'b0, cfg_reg.mother_mass_sq};
    end

    // Numerators can reach 33 bits; the model works on 64-bit values, so
    // keep the carry.
    logic          s1_na_hi_reg;
    logic          s1_nb_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= point.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_oor_reg   <= (point.data.ac_sq > cfg_reg.ac_range_max)
                         || (point.data.ac_sq < cfg_reg.ac_range_min);
            s1_ab_reg    <= point.data.ab_sq;
            s1_na_reg    <= na_next[W-1:0];
            s1_na_hi_reg <= na_next[W];
            s1_nb_reg    <= nb_next[W-1:0];
            s1_nb_hi_reg <= nb_next[W];
            s1_den_reg   <= {point.data.ac_sq, 2'b00};
        end
    end

    // ---------------- Stages 2-3: products of numerators ----------------
    // 33x33 products split into a 32x32 core plus carry terms.
    logic          s2_valid_reg;
    logic          s2_oor_reg;
    logic [W-1:0]  s2_ab_reg;
    logic [W+1:0]  s2_den_reg;
    logic [63:0]   s2_aa_reg, s2_bb_reg, s2_ab_core_reg;
    logic [W:0]    s2_na_reg, s2_nb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_oor_reg     <= s1_oor_reg;
            s2_ab_reg      <= s1_ab_reg;
            s2_den_reg     <= s1_den_reg;
            s2_aa_reg      <= s1_na_reg * s1_na_reg;
            s2_bb_reg      <= s1_nb_reg * s1_nb_reg;
            s2_ab_core_reg <= s1_na_reg * s1_nb_reg;
            s2_na_reg      <= {s1_na_hi_reg, s1_na_reg};
            s2_nb_reg      <= {s1_nb_hi_reg, s1_nb_reg};
        end
    end

    // Add the carry-bit cross terms: (h*2^32 + l)(g*2^32 + m).
    localparam int PW = 2 * W + 2;
    logic          s3_valid_reg;
    logic          s3_oor_reg;
    logic [W-1:0]  s3_ab_reg;
    logic [W+1:0]  s3_den_reg;
    logic [PW-1:0] s3_paa_reg, s3_pbb_reg, s3_pab_reg;

    function automatic logic [PW-1:0] fix_prod(
        input logic [63:0] core,
        input logic [W:0]  x,
        input logic [W:0]  y
    );
        logic [PW-1:0] acc;
        begin
            acc = {2'b00, core};
            if (x[W])
                acc = acc + ({{(PW-W){1'b0}}, y[W-1:0]} << W);
            if (y[W])
                acc = acc + ({{(PW-W){1'b0}}, x[W-1:0]} << W);
            if (x[W] && y[W])
                acc = acc + ({{(PW-1){1'b0}}, 1'b1} << (2 * W));
            fix_prod = acc;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_oor_reg <= s2_oor_reg;
            s3_ab_reg  <= s2_ab_reg;
            s3_den_reg <= s2_den_reg;
            s3_paa_reg <= fix_prod(s2_aa_reg, s2_na_reg, s2_na_reg);
            s3_pbb_reg <= fix_prod(s2_bb_reg, s2_nb_reg, s2_nb_reg);
            s3_pab_reg <= fix_prod(s2_ab_core_reg, s2_na_reg, s2_nb_reg);
        end
    end

    // ---------------- Divider: one digit per stage, three lanes ----------------
    // Restoring division of a 66-bit product by a 34-bit divisor. A quotient
    // bit at or above 2^32 means saturation, tracked by a sticky flag.
    localparam int RW = W + 3;

    logic          dv_valid_reg [DIV_N+1];
    logic          dv_oor_reg   [DIV_N+1];
    logic [W-1:0]  dv_ab_reg    [DIV_N+1];
    logic [W+1:0]  dv_den_reg   [DIV_N+1];
    logic [PW-1:0] dv_num_reg   [DIV_N+1][3];
    logic [RW-1:0] dv_rem_reg   [DIV_N+1][3];
    logic [W-1:0]  dv_quo_reg   [DIV_N+1][3];
    logic          dv_sat_reg   [DIV_N+1][3];

    always_comb
    begin
        dv_valid_reg[0] = s3_valid_reg;
        dv_oor_reg[0]   = s3_oor_reg;
        dv_ab_reg[0]    = s3_ab_reg;
        dv_den_reg[0]   = s3_den_reg;
        dv_num_reg[0][0] = s3_paa_reg;
        dv_num_reg[0][1] = s3_pbb_reg;
        dv_num_reg[0][2] = s3_pab_reg;
        for (int l = 0; l < 3; l++)
        begin
            dv_rem_reg[0][l] = '0;
            dv_quo_reg[0][l] = '0;
            dv_sat_reg[0][l] = (s3_den_reg == '0);
        end
    end

    for (genvar s = 0; s < DIV_N; s++)
    begin : g_div
        localparam int BI = DIV_N - 1 - s;
        logic [RW-1:0] rem_next [3];
        logic [W-1:0]  quo_next [3];
        logic          sat_next [3];
        logic [RW-1:0] sh;
        always_comb
        begin
            sh = '0;
            for (int l = 0; l < 3; l++)
            begin
                sh = {dv_rem_reg[s][l][RW-2:0], dv_num_reg[s][l][BI]};
                quo_next[l] = dv_quo_reg[s][l];
                sat_next[l] = dv_sat_reg[s][l];
                if (sh >= {1'b0, dv_den_reg[s]})
                begin
                    rem_next[l] = sh - {1'b0, dv_den_reg[s]};
                    if (BI >= W)
                        sat_next[l] = 1'b1;
                    else
                        quo_next[l][BI % W] = 1'b1;
                end
                else
                begin
                    rem_next[l] = sh;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[s+1] <= dv_valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_oor_reg[s+1] <= dv_oor_reg[s];
                dv_ab_reg[s+1]  <= dv_ab_reg[s];
                dv_den_reg[s+1] <= dv_den_reg[s];
                for (int l = 0; l < 3; l++)
                begin
                    dv_num_reg[s+1][l] <= dv_num_reg[s][l];
                    dv_rem_reg[s+1][l] <= rem_next[l];
                    dv_quo_reg[s+1][l] <= quo_next[l];
                    dv_sat_reg[s+1][l] <= sat_next[l];
                end
            end
        end
    end

    // ---------------- Clamp the energies against the masses ----------------
    logic          c1_valid_reg;
    logic          c1_oor_reg;
    logic [W-1:0]  c1_ab_reg;
    logic [W-1:0]  c1_ka_reg, c1_kb_reg, c1_eab_reg;
    logic [W-1:0]  c1_da_reg, c1_db_reg;

    logic [W-1:0] eaa, ebb, eab, ka, kb;
    always_comb
    begin
        eaa = dv_sat_reg[DIV_N][0] ? SAT32 : dv_quo_reg[DIV_N][0];
        ebb = dv_sat_reg[DIV_N][1] ? SAT32 : dv_quo_reg[DIV_N][1];
        eab = dv_sat_reg[DIV_N][2] ? SAT32 : dv_quo_reg[DIV_N][2];
        ka  = (eaa < cfg_reg.a_mass_sq) ? eaa : cfg_reg.a_mass_sq;
        kb  = (ebb < cfg_reg.b_mass_sq) ? ebb : cfg_reg.b_mass_sq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg <= dv_valid_reg[DIV_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_oor_reg <= dv_oor_reg[DIV_N];
            c1_ab_reg  <= dv_ab_reg[DIV_N];
            c1_ka_reg  <= ka;
            c1_kb_reg  <= kb;
            c1_eab_reg <= eab;
            c1_da_reg  <= eaa - ka;
            c1_db_reg  <= ebb - kb;
        end
    end

    // ---------------- Momentum product ----------------
    logic          c2_valid_reg;
    logic [63:0]   c2_pp_reg;
    localparam int SIDE_W = 1 + 3 * W;
    logic [SIDE_W-1:0] c2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c2_valid_reg <= c1_valid_reg;
        end
    end

    // The side word carries the flag, AB, the clamped A energy and EAB; the
    // clamped B energy travels next to it, and the two are added after the
    // square root.
    logic [W-1:0] c2_kb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_pp_reg   <= c1_da_reg * c1_db_reg;
            c2_side_reg <= {c1_oor_reg, c1_ab_reg, c1_ka_reg, c1_eab_reg};
            c2_kb_reg   <= c1_kb_reg;
        end
    end

    // ---------------- Square root ----------------
    logic              sq_valid;
    logic [W-1:0]      sq_root;
    logic [SIDE_W-1:0] sq_side;
    logic [W-1:0]      sq_kb;

    dalitz_isqrt #(
        .SIDE_W (SIDE_W + W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c2_valid_reg),
        .in_rad    (c2_pp_reg),
        .in_side   ({c2_side_reg, c2_kb_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  ({sq_side, sq_kb})
    );

    // ---------------- Bounds ----------------
    logic          b1_valid_reg;
    logic          b1_oor_reg;
    logic [W-1:0]  b1_ab_reg;
    logic [W+1:0]  b1_lower_reg;
    logic [W+1:0]  b1_upper_reg;

    logic          q_oor;
    logic [W-1:0]  q_ab, q_ka, q_eab;
    logic [W:0]    base;
    logic [W-1:0]  dif;
    logic [W:0]    sum_ep;
    always_comb
    begin
        {q_oor, q_ab, q_ka, q_eab} = sq_side;
        base   = {1'b0, q_ka} + {1'b0, sq_kb};
        dif    = (q_eab > sq_root) ? q_eab - sq_root : '0;
        sum_ep = {1'b0, q_eab} + {1'b0, sq_root};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_oor_reg   <= q_oor;
            b1_ab_reg    <= q_ab;
            b1_lower_reg <= {1'b0, base} + {1'b0, dif, 1'b0};
            b1_upper_reg <= {1'b0, base} + {sum_ep, 1'b0};
        end
    end

    // ---------------- Output register ----------------
    dalitz_pkg::bounds_t out_reg;
    logic [W-1:0] lower_s, upper_s;
    always_comb
    begin
        lower_s = (b1_lower_reg[W+1:W] != 2'b00) ? SAT32 : b1_lower_reg[W-1:0];
        upper_s = (b1_upper_reg[W+1:W] != 2'b00) ? SAT32 : b1_upper_reg[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (b1_oor_reg)
            begin
                out_reg <= '{in_plot: 1'b0, ac_out_of_range: 1'b1,
                             ab_lower: '0, ab_upper: '0};
            end
            else
            begin
                out_reg.in_plot         <= (b1_ab_reg >= lower_s) && (b1_ab_reg <= upper_s);
                out_reg.ac_out_of_range <= 1'b0;
                out_reg.ab_lower        <= lower_s;
                out_reg.ab_upper        <= upper_s;
            end
        end
    end

    assign bounds.valid = out_valid_reg;
    assign bounds.data  = out_reg;
endmodule

// File: rtl/core/dalitz_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dalitz boundary check port checker
// Watches the top-level channels and checks result consistency.
// ----------------------------------------------------------------------------
module dalitz_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input dalitz_pkg::bounds_t out_data
);
    // A flagged point carries zero bounds and is never inside.
    a_flag_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.ac_out_of_range |->
            !out_data.in_plot && out_data.ab_lower == '0 && out_data.ab_upper == '0)
        else $error("flagged item has non-zero bounds");

    // The lower bound never exceeds the upper bound on an unflagged item.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ac_out_of_range |-> out_data.ab_lower <= out_data.ab_upper)
        else $error("lower bound above upper bound");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
endmodule

bind dalitz_boundary_check dalitz_checker u_dalitz_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (bounds.valid),
    .out_ready (bounds.ready),
    .out_data  (bounds.data)
);

// File: bench/tb_dalitz_boundary_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dalitz boundary check testbench
// Drives squared-mass points through the block under a series of mass and
// range settings and checks every result item, field by field, against an
// in-bench prediction of the kinematic bounds or a typed expectation. Two short
// directed tables come first; random points, mostly aimed at the bounds,
// follow, under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_dalitz_boundary_check;

    localparam logic [dalitz_pkg::MASS_W-1:0] SAT = '1;
    // Index past the last register; the block must ignore writes to it.
    localparam logic [dalitz_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 120;
    localparam int PHASE_ITEMS  = 160;
    localparam int NUM_PHASES   = 8;

    // Physical-looking masses in Q8.24: a heavy meson decaying to a kaon and
    // two pions, with the AC range taken from the mass sums.
    localparam logic [31:0] PHY_M  = 32'd58345000;
    localparam logic [31:0] PHY_A  = 32'd4089000;
    localparam logic [31:0] PHY_B  = 32'd326800;
    localparam logic [31:0] PHY_C  = 32'd326800;
    localparam logic [31:0] PHY_LO = 32'd6728000;
    localparam logic [31:0] PHY_HI = 32'd49930000;

    typedef struct {
        logic [31:0] ab;
        logic [31:0] ac;
        bit          typed;
        bit          in_plot;
        bit          flagged;
        logic [31:0] lower;
        logic [31:0] upper;
    } stim_row_t;

    logic clk;
    logic rst_n;

    dalitz_cfg_if    cfg_ch ();
    dalitz_point_if  point_ch ();
    dalitz_bounds_if bounds_ch ();

    dalitz_boundary_check uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .point  (point_ch),
        .bounds (bounds_ch)
    );

    // Mirror of the block's registers, updated on every accepted write.
    dalitz_pkg::cfg_t    masses;
    dalitz_pkg::bounds_t pending_bounds [$];

    int mismatches;
    int results_seen;
    int flagged_seen;
    int inside_seen;
    int burst_left;
    bit hold_ready;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Generous ceiling: far above the slowest legal run of this stimulus.
    initial
    begin
        #10ms;
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // floor(x*y/d), saturating at 32 bits; a zero divisor saturates too.
    function automatic logic [31:0] energy_term(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] d);
        logic [127:0] prod;
        logic [127:0] quo;
        if (d == 0)
            return SAT;
        prod = 128'(x) * 128'(y);
        quo  = prod / 128'(d);
        return (quo > 128'(SAT)) ? SAT : quo[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (32'd1 << i);
            if (64'(trial) * 64'(trial) <= x)
                root = trial;
        end
        return 64'(root);
    endfunction

    function automatic dalitz_pkg::bounds_t predict_bounds(logic [31:0] ab,
                                                           logic [31:0] ac);
        dalitz_pkg::bounds_t r;
        logic [63:0] sum;
        logic [63:0] num_a;
        logic [63:0] num_b;
        logic [63:0] e_aa;
        logic [63:0] e_bb;
        logic [63:0] e_ab;
        logic [63:0] k_a;
        logic [63:0] k_b;
        logic [63:0] mom;
        logic [63:0] diff;
        logic [63:0] lo;
        logic [63:0] hi;
        r = '0;
        if (ac > masses.ac_range_max || ac < masses.ac_range_min)
        begin
            r.ac_out_of_range = 1'b1;
            return r;
        end
        // Energy numerators; a negative one is taken by magnitude.
        sum   = 64'(ac) + 64'(masses.a_mass_sq);
        num_a = (sum >= 64'(masses.c_mass_sq)) ? sum - 64'(masses.c_mass_sq)
                                               : 64'(masses.c_mass_sq) - sum;
        sum   = 64'(ac) + 64'(masses.b_mass_sq);
        num_b = (64'(masses.mother_mass_sq) >= sum)
              ? 64'(masses.mother_mass_sq) - sum : sum - 64'(masses.mother_mass_sq);
        e_aa = 64'(energy_term(num_a, num_a, 64'(ac) << 2));
        e_bb = 64'(energy_term(num_b, num_b, 64'(ac) << 2));
        e_ab = 64'(energy_term(num_a, num_b, 64'(ac) << 2));
        // Momenta clamp at zero when the energy falls below the rest mass.
        k_a  = (e_aa < 64'(masses.a_mass_sq)) ? e_aa : 64'(masses.a_mass_sq);
        k_b  = (e_bb < 64'(masses.b_mass_sq)) ? e_bb : 64'(masses.b_mass_sq);
        mom  = floor_sqrt((e_aa - k_a) * (e_bb - k_b));
        diff = (e_ab > mom) ? e_ab - mom : 64'd0;
        lo   = k_a + k_b + 2 * diff;
        hi   = k_a + k_b + 2 * (e_ab + mom);
        r.ab_lower = (lo > 64'(SAT)) ? SAT : lo[31:0];
        r.ab_upper = (hi > 64'(SAT)) ? SAT : hi[31:0];
        r.in_plot  = (ab >= r.ab_lower && ab <= r.ab_upper);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. Everything changes on the falling edge; handshakes are judged
    // on the rising edge from the values that stood before it.
    // ------------------------------------------------------------------------

    task automatic write_reg(logic [dalitz_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_ch.valid      = 1'b1;
        cfg_ch.data.index = idx;
        cfg_ch.data.data  = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            dalitz_pkg::REG_MOTHER_MASS_SQ: masses.mother_mass_sq = value;
            dalitz_pkg::REG_A_MASS_SQ:      masses.a_mass_sq      = value;
            dalitz_pkg::REG_B_MASS_SQ:      masses.b_mass_sq      = value;
            dalitz_pkg::REG_C_MASS_SQ:      masses.c_mass_sq      = value;
            dalitz_pkg::REG_AC_RANGE_MIN:   masses.ac_range_min   = value;
            dalitz_pkg::REG_AC_RANGE_MAX:   masses.ac_range_max   = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Waits for the pipe to empty so that a new setting cannot touch a point
    // still in flight, then loads all six registers.
    task automatic load_masses(logic [31:0] m, logic [31:0] a, logic [31:0] b,
                               logic [31:0] c, logic [31:0] lo, logic [31:0] hi);
        point_ch.valid = 1'b0;
        burst_left     = 0;
        wait (pending_bounds.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_reg(dalitz_pkg::REG_MOTHER_MASS_SQ, m);
        write_reg(dalitz_pkg::REG_A_MASS_SQ, a);
        write_reg(dalitz_pkg::REG_B_MASS_SQ, b);
        write_reg(dalitz_pkg::REG_C_MASS_SQ, c);
        write_reg(dalitz_pkg::REG_AC_RANGE_MIN, lo);
        write_reg(dalitz_pkg::REG_AC_RANGE_MAX, hi);
    endtask

    // Sends one point. The sender runs in bursts; valid drops for a while
    // between most bursts. Within a burst valid stays high.
    task automatic send_point(logic [31:0] ab, logic [31:0] ac, bit typed,
                              dalitz_pkg::bounds_t want);
        if (burst_left == 0)
        begin
            point_ch.valid = 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        point_ch.valid      = 1'b1;
        point_ch.data.ab_sq = ab;
        point_ch.data.ac_sq = ac;
        do
            @(posedge clk);
        while (!point_ch.ready);
        pending_bounds.push_back(typed ? want : predict_bounds(ab, ac));
        burst_left--;
        @(negedge clk);
    endtask

    // The receiver alternates between runs of ready and runs of stall, with
    // occasional long stretches of steady ready.
    initial
    begin
        int run;
        bounds_ch.ready = 1'b0;
        hold_ready      = 1'b0;
        run = 0;
        forever
        begin
            @(negedge clk);
            if (run == 0)
            begin
                hold_ready = ~hold_ready;
                if (hold_ready)
                    run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 12);
                else
                    run = $urandom_range(1, 8);
            end
            run--;
            bounds_ch.ready = hold_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        dalitz_pkg::bounds_t want;
        dalitz_pkg::bounds_t got;
        if (rst_n && bounds_ch.valid && bounds_ch.ready)
        begin
            got = bounds_ch.data;
            if (pending_bounds.size() == 0)
            begin
                mismatches++;
                $display("%0t: result item with nothing expected: %h", $time, got);
            end
            else
            begin
                want = pending_bounds.pop_front();
                results_seen++;
                flagged_seen += got.ac_out_of_range;
                inside_seen  += got.in_plot;
                if (got.in_plot !== want.in_plot)
                begin
                    mismatches++;
                    $display("%0t: in_plot expected %b actual %b", $time,
                             want.in_plot, got.in_plot);
                end
                if (got.ac_out_of_range !== want.ac_out_of_range)
                begin
                    mismatches++;
                    $display("%0t: ac_out_of_range expected %b actual %b", $time,
                             want.ac_out_of_range, got.ac_out_of_range);
                end
                if (got.ab_lower !== want.ab_lower)
                begin
                    mismatches++;
                    $display("%0t: ab_lower expected %h actual %h", $time,
                             want.ab_lower, got.ab_lower);
                end
                if (got.ab_upper !== want.ab_upper)
                begin
                    mismatches++;
                    $display("%0t: ab_upper expected %h actual %h", $time,
                             want.ab_upper, got.ab_upper);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tables
    // ------------------------------------------------------------------------

    // Under the reset setting every register is zero, so the range holds only
    // AC = 0. That point hits the zero-mass case: all energy terms saturate,
    // the momentum is exactly saturated, so the band is the whole axis.
    stim_row_t reset_rows [5] = '{
        '{32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 32'd0, SAT},
        '{SAT,   32'd0, 1'b1, 1'b1, 1'b0, 32'd0, SAT},
        '{32'd0, 32'd1, 1'b1, 1'b0, 1'b1, 32'd0, 32'd0},
        '{SAT,   SAT,   1'b1, 1'b0, 1'b1, 32'd0, 32'd0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 1'b1, 32'd0, 32'd0}
    };

    // Physical setting: range edges, just outside them, AB extremes and interior points.
    stim_row_t phys_rows [12] = '{
        '{32'd0, PHY_LO - 1, 1'b1, 1'b0, 1'b1, 32'd0, 32'd0},
        '{32'd0, PHY_HI + 1, 1'b1, 1'b0, 1'b1, 32'd0, 32'd0},
        '{32'd0, 32'd0,      1'b1, 1'b0, 1'b1, 32'd0, 32'd0},
        '{SAT,   SAT,        1'b1, 1'b0, 1'b1, 32'd0, 32'd0},
        '{32'd0, PHY_LO,     1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{SAT,   PHY_LO,     1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{32'd0, PHY_HI,     1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{SAT,   PHY_HI,     1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{32'd20000000, 32'd20000000, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{32'd30000000, 32'd20000000, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{32'd10000000, 32'd30000000, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
        '{32'd45000000, 32'd10000000, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}
    };

    task automatic walk_rows(stim_row_t rows [], int count);
        dalitz_pkg::bounds_t want;
        for (int i = 0; i < count; i++)
        begin
            want.in_plot         = rows[i].in_plot;
            want.ac_out_of_range = rows[i].flagged;
            want.ab_lower        = rows[i].lower;
            want.ab_upper        = rows[i].upper;
            send_point(rows[i].ab, rows[i].ac, rows[i].typed, want);
        end
    endtask

    // Random point: mostly AC inside the range with AB usually placed on, next to or
    // between the bounds; the rest is unrestricted noise over both fields.
    task automatic send_random_point();
        logic [31:0] ab;
        logic [31:0] ac;
        dalitz_pkg::bounds_t band;
        ab = $urandom();
        ac = $urandom();
        if ($urandom_range(0, 3) != 0 && masses.ac_range_min <= masses.ac_range_max)
        begin
            case ($urandom_range(0, 5))
                0: ac = masses.ac_range_min;
                1: ac = masses.ac_range_max;
                default: ac = $urandom_range(masses.ac_range_max, masses.ac_range_min);
            endcase
            band = predict_bounds(ab, ac);
            case ($urandom_range(0, 6)) inside
                0: ab = band.ab_lower;
                1: ab = band.ab_upper;
                2: ab = band.ab_lower - 1;
                3: ab = band.ab_upper + 1;
                [4:5]: ab = $urandom_range(band.ab_upper, band.ab_lower);
                default: ;
            endcase
        end
        send_point(ab, ac, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [31:0] m;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] lo;
        logic [31:0] hi;
        int          waited;

        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        point_ch.valid     = 1'b0;
        point_ch.data      = '0;
        masses             = '0;
        mismatches         = 0;
        results_seen       = 0;
        flagged_seen       = 0;
        inside_seen        = 0;
        burst_left         = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        walk_rows(reset_rows, 5);

        load_masses(PHY_M, PHY_A, PHY_B, PHY_C, PHY_LO, PHY_HI);
        // A write to a nonexistent register must leave the setting unchanged.
        write_reg(REG_UNUSED, SAT);
        walk_rows(phys_rows, 12);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    m = PHY_M; a = PHY_A; b = PHY_B; c = PHY_C; lo = PHY_LO; hi = PHY_HI;
                end
                1:
                begin
                    // Every register at its top value.
                    m = SAT; a = SAT; b = SAT; c = SAT; lo = SAT; hi = SAT;
                end
                2:
                begin
                    // All masses at the top, the whole AC axis allowed.
                    m = SAT; a = SAT; b = SAT; c = SAT; lo = '0; hi = SAT;
                end
                3:
                begin
                    // Massless daughters and parent, whole axis: zero AC in range.
                    m = '0; a = '0; b = '0; c = '0; lo = '0; hi = SAT;
                end
                4:
                begin
                    // Inverted range: every point is flagged.
                    m = $urandom(); a = $urandom(); b = $urandom(); c = $urandom();
                    hi = $urandom_range(32'h7FFF_FFFF, 0); lo = hi + $urandom_range(1, 1000);
                end
                5:
                begin
                    // Heavy C makes the A numerator negative across the range.
                    m = $urandom_range(32'h4000_0000, 32'h1000_0000);
                    a = $urandom_range(32'h0100_0000, 0);
                    b = $urandom_range(32'h0100_0000, 0);
                    c = $urandom_range(SAT, 32'h8000_0000);
                    lo = $urandom_range(32'h0800_0000, 1); hi = m;
                end
                default:
                begin
                    m = $urandom(); a = $urandom(); b = $urandom(); c = $urandom();
                    lo = $urandom(); hi = $urandom();
                    if (lo > hi)
                    begin
                        lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi;
                    end
                end
            endcase
            load_masses(m, a, b, c, lo, hi);
            repeat (PHASE_ITEMS) send_random_point();
        end

        point_ch.valid = 1'b0;
        waited = 0;
        while (pending_bounds.size() != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d result items over %0d mass settings: %0d inside the plot,",
                 results_seen, NUM_PHASES + 2, inside_seen);
        $display("%0d with AC out of range, %0d still outstanding.",
                 flagged_seen, pending_bounds.size());
        if (mismatches == 0 && pending_bounds.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
